### rtl/gyro_calibrate_deadband_integrate_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gyro calibrate / dead band / integrate block
// Concurrent checks sampled on the rising edge of clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GYRO_CALIBRATE_DEADBAND_INTEGRATE_ASSERT_SVH
`define GYRO_CALIBRATE_DEADBAND_INTEGRATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define GCDI_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gcdi assertion failed");

// expression must never be true outside reset
`define GCDI_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("gcdi forbidden condition seen");

`else

`define GCDI_ASSERT(label, prop)
`define GCDI_ASSERT_NEVER(label, expr)

`endif

`endif

### rtl/gcdi_pkg.sv
// ----------------------------------------------------------------------------
// gcdi_pkg
// Shared types and fixed widths of the gyro calibrate / integrate block.
// ----------------------------------------------------------------------------
package gcdi_pkg;

   localparam int SAMPLE_W = 16;
   localparam int YAW_W    = 48;
   localparam int SQRT_W   = 32;
   localparam int BAND_W   = 20;
   localparam int DB_W     = 22;

   // calibration length; a power of two, so the averages are shifts
   localparam int CAL_COUNT = 256;
   localparam int CAL_SHIFT = $clog2(CAL_COUNT);

   localparam logic [SQRT_W-1:0] SQRT_FIRST_BIT = 32'h4000_0000;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_EXEC   = 8'b00000010,
      ST_MEAN   = 8'b00000100,
      ST_WALK   = 8'b00001000,
      ST_SQRT   = 8'b00010000,
      ST_FILT   = 8'b00100000,
      ST_YAW    = 8'b01000000,
      ST_RESULT = 8'b10000000
   } state_type;

   typedef enum logic [2:0] {
      PH_SETTLE  = 3'b001,
      PH_COLLECT = 3'b010,
      PH_RUN     = 3'b100
   } phase_type;

   typedef struct packed {
      logic capture;
      logic settle_inc;
      logic store;
      logic mean_load;
      logic walk_start;
      logic sqrt_start;
      logic dev_load;
      logic diff_load;
      logic filt_load;
      logic yaw_load;
      logic result_load;
      logic res_calib;
      logic res_run;
   } ctrl_cmd_type;

   typedef struct packed {
      logic settle_last;
      logic collect_full;
      logic walk_busy;
      logic sqrt_busy;
   } ctrl_status_type;

endpackage

### rtl/gcdi_if.sv
// ----------------------------------------------------------------------------
// gcdi channel interfaces
// Valid/ready channels for raw rate samples and for integrator results.
// ----------------------------------------------------------------------------
interface gcdi_req_if;
   import gcdi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] rate_sample;

   modport source (output valid, output rate_sample, input ready);
   modport sink   (input valid, input rate_sample, output ready);
endinterface

interface gcdi_rsp_if;
   import gcdi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       calibrating;
   logic signed [SAMPLE_W-1:0] filtered_rate;
   logic signed [YAW_W-1:0]    yaw_count;
   logic signed [SAMPLE_W-1:0] bias_mean;
   logic        [SAMPLE_W-1:0] noise_deviation;

   modport source (output valid, output calibrating, output filtered_rate,
                   output yaw_count, output bias_mean, output noise_deviation,
                   input ready);
   modport sink   (input valid, input calibrating, input filtered_rate,
                   input yaw_count, input bias_mean, input noise_deviation,
                   output ready);
endinterface

### rtl/gcdi_ctrl.sv
// ----------------------------------------------------------------------------
// gcdi_ctrl
// Sequencer: tracks the operating phase, steps the datapath through each
// transaction and owns the result valid flag.
// ----------------------------------------------------------------------------
`include "gyro_calibrate_deadband_integrate_assert.svh"

module gcdi_ctrl #(
   parameter int SETTLE = 100
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  gcdi_pkg::ctrl_status_type status,
   output gcdi_pkg::ctrl_cmd_type    cmd
);
   import gcdi_pkg::*;

   localparam phase_type PHASE_RESET = (SETTLE == 0) ? PH_COLLECT : PH_SETTLE;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      item_calib_ff, item_calib_in;
   logic      item_run_ff, item_run_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      item_calib_in = item_calib_ff;
      item_run_in   = item_run_ff;
      cmd           = '0;
      cmd.res_calib = item_calib_ff;
      cmd.res_run   = item_run_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (phase_ff)
               PH_SETTLE: begin
                  cmd.settle_inc = 1'b1;
                  item_calib_in  = 1'b1;
                  item_run_in    = 1'b0;
                  if (status.settle_last) begin
                     phase_in = PH_COLLECT;
                  end
                  state_in = ST_RESULT;
               end
               PH_COLLECT: begin
                  if (!status.collect_full) begin
                     cmd.store     = 1'b1;
                     item_calib_in = 1'b1;
                     item_run_in   = 1'b0;
                     state_in      = ST_RESULT;
                  end else begin
                     // completion transaction: sample is dropped
                     item_calib_in = 1'b0;
                     item_run_in   = 1'b0;
                     state_in      = ST_MEAN;
                  end
               end
               PH_RUN: begin
                  cmd.diff_load = 1'b1;
                  item_calib_in = 1'b0;
                  item_run_in   = 1'b1;
                  state_in      = ST_FILT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MEAN: begin
            cmd.mean_load  = 1'b1;
            cmd.walk_start = 1'b1;
            state_in       = ST_WALK;
         end
         ST_WALK: begin
            if (!status.walk_busy) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!status.sqrt_busy) begin
               cmd.dev_load = 1'b1;
               phase_in     = PH_RUN;
               state_in     = ST_RESULT;
            end
         end
         ST_FILT: begin
            cmd.filt_load = 1'b1;
            state_in      = ST_YAW;
         end
         ST_YAW: begin
            cmd.yaw_load = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PHASE_RESET;
         item_calib_ff <= 1'b0;
         item_run_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         item_calib_ff <= item_calib_in;
         item_run_ff   <= item_run_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `GCDI_ASSERT(a_run_is_final, (phase_ff == PH_RUN) |=> (phase_ff == PH_RUN))
   `GCDI_ASSERT(a_run_entry_after_sqrt, $rose(phase_ff == PH_RUN) |-> $past(state_ff == ST_SQRT))
   `GCDI_ASSERT_NEVER(a_no_result_overwrite, cmd.result_load && rsp_valid_ff && !rsp_ready)

endmodule

### rtl/gcdi_datapath.sv
// ----------------------------------------------------------------------------
// gcdi_datapath
// Sample store, running sum, shift averages, sum-of-squares walk, integer
// square root, dead band and saturating trapezoid accumulator.
// ----------------------------------------------------------------------------
`include "gyro_calibrate_deadband_integrate_assert.svh"

module gcdi_datapath #(
   parameter int SETTLE = 100
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gcdi_pkg::ctrl_cmd_type               cmd,
   output gcdi_pkg::ctrl_status_type            status,
   input  logic signed [gcdi_pkg::SAMPLE_W-1:0] req_rate_sample,
   output logic                                 rsp_calibrating,
   output logic signed [gcdi_pkg::SAMPLE_W-1:0] rsp_filtered_rate,
   output logic signed [gcdi_pkg::YAW_W-1:0]    rsp_yaw_count,
   output logic signed [gcdi_pkg::SAMPLE_W-1:0] rsp_bias_mean,
   output logic        [gcdi_pkg::SAMPLE_W-1:0] rsp_noise_deviation
);
   import gcdi_pkg::*;

   localparam int IDX_W  = CAL_SHIFT;
   localparam int CNT_W  = $clog2(CAL_COUNT + 1);
   localparam int SET_W  = (SETTLE < 1) ? 1 : $clog2(SETTLE + 1);
   localparam int SUM_W  = SAMPLE_W + IDX_W;
   localparam int SQ_W   = 2 * SAMPLE_W + IDX_W;

   localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(CAL_COUNT - 1);
   localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(CAL_COUNT - 1);
   localparam logic signed [DB_W-1:0] SAT_HI  = DB_W'(32767);
   localparam logic signed [DB_W-1:0] SAT_LO  = -DB_W'(32768);

   // capture, settle and collect
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic        [SET_W-1:0]    settle_cnt_ff;
   logic        [CNT_W-1:0]    sample_cnt_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic        [SAMPLE_W-1:0] store_mem [CAL_COUNT];

   // mean, truncated toward zero
   logic                       sum_neg;
   logic signed [SUM_W-1:0]    sum_round;

   // walk
   logic                 walk_act_ff;
   logic                 rd_vld_ff;
   logic                 prod_vld_ff;
   logic [IDX_W-1:0]     walk_idx_ff;
   logic [SAMPLE_W-1:0]  rd_data_ff;
   logic signed [SAMPLE_W:0] walk_diff;
   logic [SAMPLE_W:0]    walk_neg;
   logic [SAMPLE_W-1:0]  walk_abs;
   logic [SQRT_W-1:0]    prod_ff;
   logic [SQ_W-1:0]      sq_ff;

   // square root
   logic [SQRT_W-1:0] sqv_ff;
   logic [SQRT_W-1:0] root_ff;
   logic [SQRT_W-1:0] bit_ff;
   logic [SQRT_W:0]   trial;
   logic [SAMPLE_W-1:0] root16;

   // calibration results
   logic signed [SAMPLE_W-1:0] mean_ff;
   logic        [SAMPLE_W-1:0] dev_ff;
   logic        [BAND_W-1:0]   band_ff;

   // run path
   logic signed [SAMPLE_W:0]   d_ff;
   logic signed [DB_W-1:0]     d_ext, d4, band_ext, thr_ext;
   logic signed [DB_W-1:0]     exc_pos, exc_neg, exc;
   logic signed [SAMPLE_W-1:0] filt_sat;
   logic signed [SAMPLE_W-1:0] filt_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic signed [SAMPLE_W:0]   trap;
   logic signed [YAW_W:0]      yaw_sum;
   logic signed [YAW_W-1:0]    yaw_ff;
   logic signed [YAW_W-1:0]    yaw_in;

   // result register
   logic                       res_calib_ff;
   logic signed [SAMPLE_W-1:0] res_filt_ff;
   logic signed [YAW_W-1:0]    res_yaw_ff;
   logic signed [SAMPLE_W-1:0] res_mean_ff;
   logic        [SAMPLE_W-1:0] res_dev_ff;

   assign status.settle_last  = (({1'b0, settle_cnt_ff} + (SET_W+1)'(1)) ==
                                 (SET_W+1)'(SETTLE));
   assign status.collect_full = (sample_cnt_ff == CNT_W'(CAL_COUNT));
   assign status.walk_busy    = walk_act_ff || rd_vld_ff || prod_vld_ff;
   assign status.sqrt_busy    = (bit_ff != '0);

   // ---------------- capture, settle count, store and sum ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_rate_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_cnt_ff <= '0;
         sample_cnt_ff <= '0;
         sum_ff        <= '0;
      end else begin
         if (cmd.settle_inc) begin
            settle_cnt_ff <= settle_cnt_ff + SET_W'(1);
         end
         if (cmd.store) begin
            sample_cnt_ff <= sample_cnt_ff + CNT_W'(1);
            sum_ff        <= sum_ff + SUM_W'(sample_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[sample_cnt_ff[IDX_W-1:0]] <= sample_ff;
      end
      rd_data_ff <= store_mem[walk_idx_ff];
   end

   // ---------------- mean: bias a negative sum up before the shift ----------------
   assign sum_neg   = sum_ff[SUM_W-1];
   assign sum_round = sum_ff + (sum_neg ? ROUND_ADD : '0);

   // ---------------- sum of squared deviations ----------------
   assign walk_diff = $signed({rd_data_ff[SAMPLE_W-1], rd_data_ff}) -
                      $signed({mean_ff[SAMPLE_W-1], mean_ff});
   assign walk_neg  = ~walk_diff + (SAMPLE_W+1)'(1);
   assign walk_abs  = walk_diff[SAMPLE_W] ? walk_neg[SAMPLE_W-1:0]
                                          : walk_diff[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_act_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         walk_idx_ff <= '0;
      end else begin
         rd_vld_ff   <= walk_act_ff;
         prod_vld_ff <= rd_vld_ff;
         if (cmd.walk_start) begin
            walk_act_ff <= 1'b1;
            walk_idx_ff <= '0;
         end else if (walk_act_ff) begin
            if (walk_idx_ff == LAST_IDX) begin
               walk_act_ff <= 1'b0;
            end
            walk_idx_ff <= walk_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= SQRT_W'(walk_abs) * SQRT_W'(walk_abs);
      if (cmd.walk_start) begin
         sq_ff <= '0;
      end else if (prod_vld_ff) begin
         sq_ff <= sq_ff + SQ_W'(prod_ff);
      end
   end

   // ---------------- integer square root, one result bit a cycle ----------------
   assign trial  = {1'b0, root_ff} + {1'b0, bit_ff};
   assign root16 = root_ff[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (cmd.sqrt_start) begin
         bit_ff <= SQRT_FIRST_BIT;
      end else if (bit_ff != '0) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         // variance: sum of squares over CAL_COUNT
         sqv_ff  <= sq_ff[CAL_SHIFT +: SQRT_W];
         root_ff <= '0;
      end else if (bit_ff != '0) begin
         if ({1'b0, sqv_ff} >= trial) begin
            sqv_ff  <= sqv_ff - trial[SQRT_W-1:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
   end

   // ---------------- calibration results ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         dev_ff  <= '0;
         band_ff <= '0;
      end else begin
         if (cmd.mean_load) begin
            mean_ff <= $signed(sum_round[CAL_SHIFT +: SAMPLE_W]);
         end
         if (cmd.dev_load) begin
            dev_ff  <= root16;
            // band = 11 * dev, four times the 2.75 dev half-width
            band_ff <= BAND_W'({root16, 3'b000}) + BAND_W'({root16, 1'b0}) +
                       BAND_W'(root16);
         end
      end
   end

   // ---------------- dead band ----------------
   assign d_ext    = DB_W'(d_ff);
   assign d4       = d_ext <<< 2;
   assign band_ext = $signed(DB_W'(band_ff));
   assign thr_ext  = band_ext >>> 2;
   assign exc_pos  = (d4 - band_ext) >>> 2;
   assign exc_neg  = -((-(d4 + band_ext)) >>> 2);

   always_comb begin
      if (d_ext > thr_ext) begin
         exc = exc_pos;
      end else if (d_ext < -thr_ext) begin
         exc = exc_neg;
      end else begin
         exc = '0;
      end
      if (exc > SAT_HI) begin
         filt_sat = SAMPLE_W'(SAT_HI);
      end else if (exc < SAT_LO) begin
         filt_sat = SAMPLE_W'(SAT_LO);
      end else begin
         filt_sat = exc[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         d_ff <= $signed({sample_ff[SAMPLE_W-1], sample_ff}) -
                 $signed({mean_ff[SAMPLE_W-1], mean_ff});
      end
      if (cmd.filt_load) begin
         filt_ff <= filt_sat;
      end
   end

   // ---------------- trapezoid accumulator ----------------
   assign trap    = $signed({filt_ff[SAMPLE_W-1], filt_ff}) +
                    $signed({prev_ff[SAMPLE_W-1], prev_ff});
   assign yaw_sum = $signed({yaw_ff[YAW_W-1], yaw_ff}) + (YAW_W+1)'(trap);

   always_comb begin
      // clamp on overflow of the 48-bit range
      if (yaw_sum[YAW_W] != yaw_sum[YAW_W-1]) begin
         yaw_in = yaw_sum[YAW_W] ? {1'b1, {(YAW_W-1){1'b0}}} : {1'b0, {(YAW_W-1){1'b1}}};
      end else begin
         yaw_in = yaw_sum[YAW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff  <= '0;
         prev_ff <= '0;
      end else if (cmd.yaw_load) begin
         yaw_ff  <= yaw_in;
         prev_ff <= filt_ff;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         res_calib_ff <= cmd.res_calib;
         res_filt_ff  <= cmd.res_run ? filt_ff : '0;
         res_yaw_ff   <= yaw_ff;
         res_mean_ff  <= mean_ff;
         res_dev_ff   <= dev_ff;
      end
   end

   assign rsp_calibrating     = res_calib_ff;
   assign rsp_filtered_rate   = res_filt_ff;
   assign rsp_yaw_count       = res_yaw_ff;
   assign rsp_bias_mean       = res_mean_ff;
   assign rsp_noise_deviation = res_dev_ff;

   `GCDI_ASSERT_NEVER(a_store_not_full, cmd.store && status.collect_full)
   `GCDI_ASSERT_NEVER(a_sqrt_start_idle, cmd.sqrt_start && status.sqrt_busy)
   `GCDI_ASSERT(a_walk_start_idle, cmd.walk_start |-> !status.walk_busy)

endmodule

### rtl/gyro_calibrate_deadband_integrate.sv
// ----------------------------------------------------------------------------
// gyro_calibrate_deadband_integrate
// Gyro Z-rate bias calibration, dead band and saturating trapezoid yaw
// integrator: sequencer plus datapath.
// ----------------------------------------------------------------------------
//  channel    direction  payload
//  req_chan   in         rate_sample
//  rsp_chan   out        calibrating, filtered_rate, yaw_count, bias_mean,
//                        noise_deviation
//
//  Settle and collect transactions go from EXEC straight to the RESULT state;
//  run transactions first pass the difference, dead band and accumulate
//  stages (EXEC, FILT, YAW). A new sample is accepted only in IDLE, after the
//  last result is loaded. The completion transaction walks the store and
//  takes the square root (MEAN, WALK, SQRT) before it loads its result.
//  Synchronous reset, no store clearing; a waiting result stalls only the next.
// ----------------------------------------------------------------------------
module gyro_calibrate_deadband_integrate #(
   parameter int SETTLE    = 100
) (
   input  logic         clock,
   input  logic         reset,
   gcdi_req_if.sink     req_chan,
   gcdi_rsp_if.source   rsp_chan
);
   import gcdi_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   gcdi_ctrl #(
      .SETTLE (SETTLE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gcdi_datapath #(
      .SETTLE    (SETTLE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_rate_sample     (req_chan.rate_sample),
      .rsp_calibrating     (rsp_chan.calibrating),
      .rsp_filtered_rate   (rsp_chan.filtered_rate),
      .rsp_yaw_count       (rsp_chan.yaw_count),
      .rsp_bias_mean       (rsp_chan.bias_mean),
      .rsp_noise_deviation (rsp_chan.noise_deviation)
   );

endmodule
